/* hw/rtl/slisd_pkg.sv */
// ----------------------------------------------------------------------------
// slisd_pkg: shared types and constants of the sorted list store
// Capacity, field widths, operation and status codes, cell control word and
// the saturating conversion of internal counts to the 6-bit result fields.
// ----------------------------------------------------------------------------
package slisd_pkg;

  localparam int CAPACITY  = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int VALUE_W   = 32;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int FIELD_W   = 6;
  localparam int COUNT_MAX = 63;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Per-request shift command broadcast to every cell.
  typedef struct packed {
    logic ins;  // open a slot at the insert point and shift right
    logic del;  // close the slot of the first match and shift left
  } cell_ctrl_t;

  function automatic logic [FIELD_W-1:0] sat_field(input logic [CNT_W-1:0] n);
    return (int'(n) > COUNT_MAX) ? FIELD_W'(COUNT_MAX) : FIELD_W'(n);
  endfunction

endpackage

/* hw/rtl/slisd_in_if.sv */
// ----------------------------------------------------------------------------
// slisd_in_if: request channel
// Valid/ready channel carrying an operation code and a signed value.
// ----------------------------------------------------------------------------
interface slisd_in_if;
  logic                               valid;
  logic                               ready;
  logic [slisd_pkg::OPCODE_W-1:0]     opcode;
  logic signed [slisd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

/* hw/rtl/slisd_out_if.sv */
// ----------------------------------------------------------------------------
// slisd_out_if: response channel
// Valid/ready channel carrying status, match count and occupancy.
// ----------------------------------------------------------------------------
interface slisd_out_if;
  logic                           valid;
  logic                           ready;
  logic [slisd_pkg::STATUS_W-1:0] status;
  logic [slisd_pkg::FIELD_W-1:0]  match_count;
  logic [slisd_pkg::FIELD_W-1:0]  occupancy;

  modport source (output valid, output status, output match_count, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input match_count, input occupancy,
                  output ready);
endinterface

/* hw/rtl/sorted_list_insert_search_delete.sv */
// ----------------------------------------------------------------------------
// sorted_list_insert_search_delete: bounded sorted multiset of signed words
// Insert, count-matches and delete-one requests against an ascending chain
// of value cells; one response per request.
// ----------------------------------------------------------------------------
//
//  Channel    Dir  Handshake     Payload
//  request    in   valid/ready   opcode[1:0], value[31:0] signed
//  response   out  valid/ready   status[1:0], match_count[5:0], occupancy[5:0]
//
//  Flow   : one request per cycle while the response is taken; the response
//           is registered through stage 1 (cell update + flag capture), then stage 2 (count).
//  Update : all cells compare against the key in parallel; on an insert or delete
//           cells from that point up shift one place in the same cycle it is accepted.
//  Reset  : clears the fill count and the pipeline flags; cell contents are
//           not cleared; cells at or above the fill count never raise a compare flag.
//  Stalls : a stalled response holds both stages; request ready drops once
//           stage 1 holds a request as well.
//
module sorted_list_insert_search_delete (
  input  logic        clk,
  input  logic        rst,
  slisd_in_if.sink    request,
  slisd_out_if.source response
);

  // --------------------------------------------------------------------------
  // Fill count and cell chain
  // --------------------------------------------------------------------------
  logic [slisd_pkg::CNT_W-1:0]          count;
  logic [slisd_pkg::CNT_W-1:0]          count_next;
  logic [slisd_pkg::CAPACITY-1:0]       valid;
  logic [slisd_pkg::CAPACITY-1:0]       lt;
  logic [slisd_pkg::CAPACITY-1:0]       eq;
  logic signed [slisd_pkg::VALUE_W-1:0] cell_value [slisd_pkg::CAPACITY];
  slisd_pkg::cell_ctrl_t                ctrl;

  logic                  accept;
  logic                  advance;
  slisd_pkg::opcode_t    op;
  logic                  full;
  logic                  empty;
  logic                  found;
  slisd_pkg::status_t    status_next;

  // --------------------------------------------------------------------------
  // Stage 1: status, new occupancy and the captured match flags
  // --------------------------------------------------------------------------
  logic                           s1_valid;
  logic                           s1_is_search;
  slisd_pkg::status_t             s1_status;
  logic [slisd_pkg::CNT_W-1:0]    s1_count;
  logic [slisd_pkg::CAPACITY-1:0] s1_match;
  logic [slisd_pkg::CNT_W-1:0]    tally_count;

  assign advance       = !response.valid || response.ready;
  assign request.ready = !s1_valid || advance;
  assign accept        = request.valid && request.ready;
  assign op            = slisd_pkg::opcode_t'(request.opcode);

  // Cells below the fill count hold live values.
  always_comb begin
    for (int i = 0; i < slisd_pkg::CAPACITY; i++) begin
      valid[i] = slisd_pkg::CNT_W'(i) < count;
    end
  end

  assign full  = (count == slisd_pkg::CNT_W'(slisd_pkg::CAPACITY));
  assign empty = (count == '0);
  assign found = |eq;

  // Decide the shift command, status and next fill count.
  always_comb begin
    ctrl        = '0;
    status_next = slisd_pkg::ST_OK;
    count_next  = count;
    case (op)
      slisd_pkg::OP_INSERT: begin
        if (full) begin
          status_next = slisd_pkg::ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + slisd_pkg::CNT_W'(1);
        end
      end
      slisd_pkg::OP_SEARCH: begin
        if (empty) begin
          status_next = slisd_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = slisd_pkg::ST_NOTFOUND;
        end
      end
      slisd_pkg::OP_DELETE: begin
        if (empty) begin
          status_next = slisd_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = slisd_pkg::ST_NOTFOUND;
        end else begin
          ctrl.del   = accept;
          count_next = count - slisd_pkg::CNT_W'(1);
        end
      end
      slisd_pkg::OP_NOP: begin
        status_next = slisd_pkg::ST_OK;
      end
      default: begin
        status_next = slisd_pkg::ST_OK;
      end
    endcase
  end

  // Cell 0 sees an always-less left neighbor so an insert at the head loads
  // the key; the last cell sees itself on the right.
  for (genvar g = 0; g < slisd_pkg::CAPACITY; g++) begin : g_cell
    logic                                 left_lt;
    logic signed [slisd_pkg::VALUE_W-1:0] left_value;
    logic signed [slisd_pkg::VALUE_W-1:0] right_value;

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = request.value;
    end else begin : g_body
      assign left_lt    = lt[g-1];
      assign left_value = cell_value[g-1];
    end

    if (g == slisd_pkg::CAPACITY - 1) begin : g_tail
      assign right_value = cell_value[g];
    end else begin : g_inner
      assign right_value = cell_value[g+1];
    end

    slisd_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (request.value),
      .valid       (valid[g]),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[g]),
      .lt          (lt[g]),
      .eq          (eq[g])
    );
  end

  // Load the next fill count on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_search <= (op == slisd_pkg::OP_SEARCH);
      s1_status    <= status_next;
      s1_count     <= count_next;
      s1_match     <= eq;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: count the matches and hold the response
  // --------------------------------------------------------------------------
  slisd_tally u_tally (
    .match (s1_match),
    .count (tally_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (advance) begin
      response.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      response.status      <= s1_status;
      response.match_count <= s1_is_search ? slisd_pkg::sat_field(tally_count) : '0;
      response.occupancy   <= slisd_pkg::sat_field(s1_count);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  logic order_ok;

  always_comb begin
    order_ok = 1'b1;
    for (int i = 0; i < slisd_pkg::CAPACITY - 1; i++) begin
      if (valid[i+1] && (cell_value[i] > cell_value[i+1])) begin
        order_ok = 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= slisd_pkg::CNT_W'(slisd_pkg::CAPACITY))
    else $error("fill count exceeds capacity");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("fill count changed without a request");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && op == slisd_pkg::OP_INSERT && full) |=> (count == $past(count)))
    else $error("refused insert changed the fill count");

  a_notfound_flags: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_status == slisd_pkg::ST_NOTFOUND) |-> (s1_match == '0))
    else $error("not-found status with match flags set");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    order_ok)
    else $error("stored values out of ascending order");

endmodule

/* hw/rtl/slisd_cell.sv */
// ----------------------------------------------------------------------------
// slisd_cell: one slot of the sorted chain
// Holds one value, compares it with the key and takes a value from its left
// or right neighbor when the chain opens or closes a slot.
// ----------------------------------------------------------------------------
module slisd_cell (
  input  logic                                 clk,
  input  slisd_pkg::cell_ctrl_t                ctrl,
  input  logic signed [slisd_pkg::VALUE_W-1:0] key,
  input  logic                                 valid,
  input  logic                                 left_lt,
  input  logic signed [slisd_pkg::VALUE_W-1:0] left_value,
  input  logic signed [slisd_pkg::VALUE_W-1:0] right_value,
  output logic signed [slisd_pkg::VALUE_W-1:0] value,
  output logic                                 lt,
  output logic                                 eq
);

  assign lt = valid && (value < key);
  assign eq = valid && (value == key);

  // Cells below the insert/delete point hold; the rest move one place.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      value <= left_lt ? key : left_value;
    end else if (ctrl.del && !lt) begin
      value <= right_value;
    end
  end

endmodule

/* hw/rtl/slisd_tally.sv */
// ----------------------------------------------------------------------------
// slisd_tally: match counter
// Counts a contiguous run of match flags from the positions of its first and
// last flag.
// ----------------------------------------------------------------------------
module slisd_tally (
  input  logic [slisd_pkg::CAPACITY-1:0] match,
  output logic [slisd_pkg::CNT_W-1:0]    count
);

  logic [slisd_pkg::CAPACITY-1:0] first_hot;
  logic [slisd_pkg::CAPACITY-1:0] last_hot;
  logic [slisd_pkg::IDX_W-1:0]    first_idx;
  logic [slisd_pkg::IDX_W-1:0]    last_idx;

  always_comb begin
    for (int i = 0; i < slisd_pkg::CAPACITY; i++) begin
      first_hot[i] = match[i] && ((i == 0) || !match[(i == 0) ? 0 : i - 1]);
      last_hot[i]  = match[i] &&
                     ((i == slisd_pkg::CAPACITY - 1) ||
                      !match[(i == slisd_pkg::CAPACITY - 1) ? i : i + 1]);
    end
  end

  always_comb begin
    first_idx = '0;
    last_idx  = '0;
    for (int i = 0; i < slisd_pkg::CAPACITY; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | slisd_pkg::IDX_W'(i);
      end
      if (last_hot[i]) begin
        last_idx = last_idx | slisd_pkg::IDX_W'(i);
      end
    end
  end

  assign count = (|match) ?
                 slisd_pkg::CNT_W'(slisd_pkg::CNT_W'(last_idx) - slisd_pkg::CNT_W'(first_idx)
                                   + slisd_pkg::CNT_W'(1)) :
                 '0;

endmodule

/* tb/slisd_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slisd_scoreboard_pkg: expected-response tracking for the sorted list store
// Keeps a shadow copy of the ascending list and predicts the status, match
// count and occupancy of every accepted request, then checks responses in
// order against those predictions.
// ----------------------------------------------------------------------------
package slisd_scoreboard_pkg;
  import slisd_pkg::*;

  typedef struct {
    status_t              status;
    logic [FIELD_W-1:0]   match_count;
    logic [FIELD_W-1:0]   occupancy;
  } list_response_t;

  class sorted_list_tracker;
    logic signed [VALUE_W-1:0] held_values[$];
    list_response_t            pending_responses[$];
    int errors;
    int checked;
    int full_refusals;
    int peak_occupancy;

    // Apply one accepted request to the shadow list and queue its response.
    function void note_request(opcode_t op, logic signed [VALUE_W-1:0] key);
      list_response_t expected;
      int pos;
      int hits;
      expected.status = ST_OK;
      hits = 0;
      case (op)
        OP_INSERT: begin
          if (held_values.size() >= CAPACITY) begin
            expected.status = ST_FULL;
            full_refusals++;
          end else begin
            pos = 0;
            while (pos < held_values.size() && held_values[pos] < key) pos++;
            held_values.insert(pos, key);
          end
        end
        OP_SEARCH: begin
          if (held_values.size() == 0) begin
            expected.status = ST_EMPTY;
          end else begin
            foreach (held_values[i]) if (held_values[i] == key) hits++;
            if (hits == 0) expected.status = ST_NOTFOUND;
          end
        end
        OP_DELETE: begin
          if (held_values.size() == 0) begin
            expected.status = ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < held_values.size() && held_values[pos] != key) pos++;
            if (pos == held_values.size()) expected.status = ST_NOTFOUND;
            else held_values.delete(pos);
          end
        end
        default: ;
      endcase
      expected.match_count = FIELD_W'((hits > COUNT_MAX) ? COUNT_MAX : hits);
      expected.occupancy   = FIELD_W'((held_values.size() > COUNT_MAX) ?
                                      COUNT_MAX : held_values.size());
      if (held_values.size() > peak_occupancy) peak_occupancy = held_values.size();
      pending_responses.push_back(expected);
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_response(logic [STATUS_W-1:0] status,
                                 logic [FIELD_W-1:0] match_count,
                                 logic [FIELD_W-1:0] occupancy);
      list_response_t expected;
      if (pending_responses.size() == 0) begin
        $error("unexpected response: status %0d match_count %0d occupancy %0d",
               status, match_count, occupancy);
        errors++;
        return;
      end
      expected = pending_responses.pop_front();
      checked++;
      if (status !== expected.status) begin
        $error("status: expected %0d, got %0d", expected.status, status);
        errors++;
      end
      if (match_count !== expected.match_count) begin
        $error("match_count: expected %0d, got %0d", expected.match_count, match_count);
        errors++;
      end
      if (occupancy !== expected.occupancy) begin
        $error("occupancy: expected %0d, got %0d", expected.occupancy, occupancy);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the sorted list insert/search/delete store
// Directed requests hit the empty list, extreme values, duplicates and
// missing keys; random fill and drain runs then push the list between empty
// and full under three idling mixes. Every response is checked against a
// shadow list kept by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import slisd_pkg::*;
  import slisd_scoreboard_pkg::*;

  localparam int IDLE_LIMIT       = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES     = 12;    // idle wait after the last response
  localparam int RANDOM_PER_PHASE = 528;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int src_idle_pct;
  int sink_idle_pct;
  int idle_cycles;
  int requests_sent;

  sorted_list_tracker tracker;

  slisd_in_if  request_ch ();
  slisd_out_if response_ch ();

  sorted_list_insert_search_delete dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  always #5 clk = ~clk;

  // Response side: check on every accepted response, then pick the next
  // ready value. Hold ready low through reset.
  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready) begin
      tracker.check_response(response_ch.status, response_ch.match_count,
                             response_ch.occupancy);
    end
    response_ch.ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) ||
        (response_ch.valid && response_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_list_insert_search_delete verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Half the values from a tiny pool so duplicates and hits are common,
  // some extremes, the rest anywhere in the 32-bit range.
  function automatic logic signed [VALUE_W-1:0] random_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return $signed(32'($urandom_range(12))) - 32'sd6;
    if (roll < 62) begin
      case ($urandom_range(5))
        0:       return 32'sh8000_0000;
        1:       return 32'sh8000_0001;
        2:       return 32'sh7fff_ffff;
        3:       return 32'sh7fff_fffe;
        4:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Keys for search and delete: usually one that is in the list right now.
  function automatic logic signed [VALUE_W-1:0] random_key();
    if (tracker.held_values.size() != 0 && $urandom_range(99) < 70)
      return tracker.held_values[$urandom_range(tracker.held_values.size() - 1)];
    return random_value();
  endfunction

  // Present one request, idling first at the sender's rate, and hold it
  // until the block takes it. Valid stays high into the next request when
  // no gap is drawn.
  task automatic send_request(opcode_t op, logic signed [VALUE_W-1:0] key);
    while ($urandom_range(99) < src_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
    request_ch.valid  <= 1'b1;
    request_ch.opcode <= op;
    request_ch.value  <= key;
    @(posedge clk);
    while (!request_ch.ready) @(posedge clk);
    tracker.note_request(op, key);
    requests_sent++;
  endtask

  initial begin
    bit                        filling;
    int                        run_left;
    int                        roll;
    opcode_t                   op;
    logic signed [VALUE_W-1:0] key;

    tracker = new();
    request_ch.valid  <= 1'b0;
    request_ch.opcode <= OP_NOP;
    request_ch.value  <= '0;
    filling       = 1'b0;
    run_left      = 0;
    requests_sent = 0;
    src_idle_pct  = 18;
    sink_idle_pct = 57;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, then extremes, duplicates and missing keys.
    send_request(OP_SEARCH, 32'sd5);          // search on empty list
    send_request(OP_DELETE, 32'sd5);          // delete on empty list
    send_request(OP_NOP,    32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_INSERT, 32'sd0);          // duplicate goes ahead of the old one
    send_request(OP_SEARCH, 32'sd0);          // two matches
    send_request(OP_SEARCH, 32'sd7);          // no match
    send_request(OP_DELETE, 32'sd7);          // missing key leaves the list alone
    send_request(OP_DELETE, 32'sd0);
    send_request(OP_SEARCH, 32'sd0);          // one match left
    send_request(OP_SEARCH, 32'sh8000_0000);
    send_request(OP_SEARCH, 32'sh7fff_ffff);
    send_request(OP_DELETE, 32'sh8000_0000);  // delete at the head
    send_request(OP_DELETE, 32'sh7fff_ffff);  // delete at the tail
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_NOP,    -32'sd1);
    send_request(OP_SEARCH, -32'sd1);

    // Random: alternate fill-heavy and drain-heavy runs so the list swings
    // between empty and full, under each idling mix in turn.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 18; sink_idle_pct = 57; end
        1:       begin src_idle_pct = 57; sink_idle_pct = 18; end
        default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(120, 40);
        end
        run_left--;
        roll = $urandom_range(99);
        if (roll < 5)                         op = OP_NOP;
        else if (roll < (filling ? 70 : 20))  op = OP_INSERT;
        else if (roll < (filling ? 85 : 40))  op = OP_SEARCH;
        else                                  op = OP_DELETE;
        key = (op == OP_SEARCH || op == OP_DELETE) ? random_key() : random_value();
        send_request(op, key);
      end
    end

    // Stop requesting, wait out the remaining responses plus the pipeline.
    request_ch.valid <= 1'b0;
    while (tracker.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d responses, %0d errors.",
             requests_sent, tracker.checked, tracker.errors);
    $display("List peaked at %0d entries; %0d inserts refused on a full list.",
             tracker.peak_occupancy, tracker.full_refusals);
    if (tracker.errors == 0 && tracker.pending_responses.size() == 0) begin
      $display("sorted_list_insert_search_delete verification clean");
    end else begin
      $display("sorted_list_insert_search_delete verification failed");
    end
    $finish;
  end

endmodule
